FILE: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/khpra_pkg.sv
package khpra_pkg;

  localparam int NUM_TABLES_DEF    = 8;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int ENTRY_W           = 52;
  localparam logic [63:0] HEAP_BASE = 64'hFFFF_FFFF_C000_0000;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_MAP   = 2'd2,
    REQ_XLATE = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A1_TAB,
    S_A1_RD,
    S_A1_CHK,
    S_A2_TAB,
    S_A_WR,
    S_R_CHK,
    S_R_WR,
    S_T_RD,
    S_T_WT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [12:0] page_count;
    logic [63:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] entry_flags;
  } req_t;

  typedef struct packed {
    logic [63:0] result_addr;
    logic [1:0]  status;
  } rsp_t;

endpackage

FILE: design/khpra_ram.sv
module khpra_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/kernel_heap_page_run_allocator_core.sv
// channel | word type          | handshake
// --------+--------------------+------------------------
// in      | khpra_pkg::req_t   | in_valid / in_stall
// out     | khpra_pkg::rsp_t   | out_valid / out_stall
//
// one request at a time; the page table store is a single-port ram read
// and written once per cycle, so allocate scans the entries of present tables
// one at a time, then, if no run fits, whole free tables, then writes each page.
// free/map check the range before writing each page; a range miss ends early.
// after reset a clearing pass over all NUM_TABLES*512 entries runs with in_stall high.
// a finished result sits in the output register while the next word is taken.
module kernel_heap_page_run_allocator_core #(
  parameter int NUM_TABLES = khpra_pkg::NUM_TABLES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  khpra_pkg::req_t in_word,
  output logic            out_valid,
  input  logic            out_stall,
  output khpra_pkg::rsp_t out_word
);
  import khpra_pkg::*;

  localparam int DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam logic [9:0] NT = 10'(NUM_TABLES);

  state_t state, state_next;

  logic [NUM_TABLES-1:0] present;
  logic [AW-1:0]         ccnt;
  req_t                  req;
  logic [9:0]            i;
  logic [8:0]            j;
  logic [9:0]            tab, ent;
  logic [13:0]           run;
  logic [9:0]            wt, went;
  logic [12:0]           wcnt;
  logic [17:0]           vpn;
  logic [39:0]           frame;
  logic [63:0]           res;
  logic [1:0]            st;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

  khpra_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // shared helpers
  logic [13:0] run_inc1, run_inc512;
  logic [13:0] cnt_x;
  logic [9:0]  w_tab, w_ent;
  logic        w_wrap;
  logic        pres_i;
  logic [9:0]  vtab;
  logic        load_out;
  logic [63:0] run_addr_te, run_addr_t0;

  assign cnt_x      = {1'b0, req.page_count};
  assign run_inc1   = run + 14'd1;
  assign run_inc512 = run + 14'd512;
  assign w_wrap     = (went >= 10'd512);
  assign w_tab      = w_wrap ? (wt + 10'd1) : wt;
  assign w_ent      = w_wrap ? 10'd0 : went;
  assign pres_i     = (i < NT) ? present[i[TW-1:0]] : 1'b0;
  assign vtab       = {1'b0, vpn[17:9]};
  assign load_out   = !out_valid || !out_stall;
  assign run_addr_te = HEAP_BASE + (64'(tab) << 21) + (64'(ent) << 12);
  assign run_addr_t0 = HEAP_BASE + (64'(tab) << 21);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (ccnt == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_word.req_type)
            REQ_ALLOC: state_next = S_A1_TAB;
            REQ_FREE,
            REQ_MAP:   state_next = S_R_CHK;
            default:   state_next = S_T_RD;
          endcase
        end
      end
      S_A1_TAB: begin
        if (i == NT)     state_next = S_A2_TAB;
        else if (pres_i) state_next = S_A1_RD;
      end
      S_A1_RD:  state_next = S_A1_CHK;
      S_A1_CHK: begin
        if (!ram_rdata[0] && run_inc1 >= cnt_x) state_next = S_A_WR;
        else if (j == 9'd511)                    state_next = S_A1_TAB;
        else                                     state_next = S_A1_RD;
      end
      S_A2_TAB: begin
        if (i == NT) state_next = S_DONE;
        else if (!pres_i && run_inc512 >= cnt_x) state_next = S_A_WR;
      end
      S_A_WR:   if (wcnt == 13'd0) state_next = S_DONE;
      S_R_CHK: begin
        if (wcnt == 13'd0)   state_next = S_R_WR;
        else if (vtab >= NT) state_next = S_DONE;
      end
      S_R_WR:   if (wcnt == 13'd0) state_next = S_DONE;
      S_T_RD: begin
        if (req.virt_addr[47:39] != 9'h1FF || {1'b0, req.virt_addr[29:21]} >= NT)
          state_next = S_DONE;
        else
          state_next = S_T_WT;
      end
      S_T_WT:   state_next = S_DONE;
      S_DONE:   if (load_out) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // ram port and input stall
  always_comb begin
    in_stall  = (state != S_IDLE);
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = ccnt;
      end
      S_A1_RD: ram_addr = AW'({i[8:0], j});
      S_A_WR: begin
        ram_we    = (wcnt != 13'd0) && (w_tab < NT);
        ram_addr  = AW'({w_tab[8:0], w_ent[8:0]});
        ram_wdata = ENTRY_W'(3);
      end
      S_R_WR: begin
        ram_we    = (wcnt != 13'd0);
        ram_addr  = AW'(vpn);
        ram_wdata = (req.req_type == REQ_MAP) ? {frame, req.entry_flags} : '0;
      end
      S_T_RD: ram_addr = AW'({req.virt_addr[29:21], req.virt_addr[20:12]});
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ccnt      <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) ccnt <= ccnt + AW'(1);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_DONE && load_out) out_valid <= 1'b1;
      // table present marks
      if (state == S_A2_TAB && i != NT && !pres_i && run_inc512 >= cnt_x)
        present[tab[TW-1:0]] <= 1'b1;
      if (state == S_A_WR && wcnt != 13'd0 && w_wrap && w_tab < NT)
        present[w_tab[TW-1:0]] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_DONE && load_out) out_word <= '{result_addr: res, status: st};
    case (state)
      S_IDLE: begin
        req <= in_word;
        i   <= '0;
        tab <= '0;
        ent <= '0;
        run <= '0;
        res <= '0;
        st  <= ST_OK;
        wcnt  <= in_word.page_count;
        vpn   <= in_word.virt_addr[29:12];
        frame <= in_word.phys_addr[51:12];
      end
      S_A1_TAB: begin
        if (i == NT) begin
          i   <= '0;
          tab <= '0;
          run <= '0;
        end else if (!pres_i) begin
          tab <= i + 10'd1;
          ent <= '0;
          run <= '0;
          i   <= i + 10'd1;
        end else begin
          j <= '0;
        end
      end
      S_A1_CHK: begin
        if (ram_rdata[0]) begin
          tab <= i;
          ent <= {1'b0, j} + 10'd1;
          run <= '0;
        end else if (run_inc1 >= cnt_x) begin
          res  <= run_addr_te;
          wt   <= tab;
          went <= ent;
          wcnt <= run_inc1[12:0];
        end else begin
          run <= run_inc1;
        end
        if (j == 9'd511) i <= i + 10'd1;
        else             j <= j + 9'd1;
      end
      S_A2_TAB: begin
        if (i == NT) begin
          st <= ST_FULL;
        end else begin
          if (pres_i) begin
            tab <= i + 10'd1;
            run <= '0;
          end else if (run_inc512 >= cnt_x) begin
            res  <= run_addr_t0;
            wt   <= tab;
            went <= '0;
            wcnt <= req.page_count;
          end else begin
            run <= run_inc512;
          end
          i <= i + 10'd1;
        end
      end
      S_A_WR: begin
        if (wcnt != 13'd0) begin
          wt   <= w_tab;
          went <= w_ent + 10'd1;
          wcnt <= wcnt - 13'd1;
        end
      end
      S_R_CHK: begin
        if (wcnt == 13'd0) begin
          wcnt <= req.page_count;
          vpn  <= req.virt_addr[29:12];
        end else if (vtab >= NT) begin
          st <= ST_RANGE;
        end else begin
          vpn  <= vpn + 18'd1;
          wcnt <= wcnt - 13'd1;
        end
      end
      S_R_WR: begin
        if (wcnt != 13'd0) begin
          vpn   <= vpn + 18'd1;
          frame <= frame + 40'd1;
          wcnt  <= wcnt - 13'd1;
        end
      end
      S_T_RD: begin
        if (req.virt_addr[47:39] != 9'h1FF || {1'b0, req.virt_addr[29:21]} >= NT)
          st <= ST_RANGE;
      end
      S_T_WT: res <= {12'd0, ram_rdata[51:12], 12'd0};
      default: ;
    endcase
  end

endmodule

FILE: design/khpra_checker.sv
`include "assert_macros.svh"

module khpra_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input khpra_pkg::req_t in_word,
  input logic            out_valid,
  input logic            out_stall,
  input khpra_pkg::rsp_t out_word
);
  import khpra_pkg::*;

  // status code is one of the three defined ones
  `CHK_NOW(a_status_code, clk, rst, out_valid, out_word.status == ST_OK || out_word.status == ST_FULL || out_word.status == ST_RANGE, "bad status code")

  // failed requests carry a zero address
  `CHK_NOW(a_fail_zero, clk, rst, out_valid && out_word.status != ST_OK, out_word.result_addr == 64'd0, "nonzero address on failure")

  // every returned address is page aligned
  `CHK_NOW(a_aligned, clk, rst, out_valid, out_word.result_addr[11:0] == 12'd0, "unaligned result")

  // clearing pass holds off input right after reset
  `CHK_NOW(a_clear_stall, clk, rst, $past(rst), in_stall, "input taken during clear")

  // a stalled result word stays
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word), "stalled word dropped")

endmodule

bind kernel_heap_page_run_allocator_core khpra_checker u_khpra_checker (.*);
